[design/spaf_pkg.sv]
// ----------------------------------------------------------------------------
// spaf_pkg: shared types and constants of the sample pair ASCII formatter
// Holds the ASCII codes of a record, the per-lane digit result and the
// encoding of the byte sequencer states.
// ----------------------------------------------------------------------------
package spaf_pkg;

  // A value of up to 16 bits never needs more than five decimal digits.
  localparam int NUM_DIGITS  = 5;
  localparam int DIGIT_IDX_W = 3;

  // ASCII codes used in a record.
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_LF   = 8'd10;
  localparam logic [7:0] ASCII_CR   = 8'd13;
  localparam logic [7:0] ASCII_X    = 8'd88;
  localparam logic [7:0] ASCII_Y    = 8'd89;

  // Digits of one sample, digit[i] weighs 10**i, and the count of
  // significant digits (at least one).
  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digit;
    logic [DIGIT_IDX_W-1:0]     ndig;
  } lane_res_t;

  // Position of the byte sequencer inside a record.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LBL_X,
    ST_DIG_X,
    ST_LF_X,
    ST_CR_X,
    ST_LBL_Y,
    ST_DIG_Y,
    ST_LF_Y,
    ST_CR_Y
  } fmt_state_t;

endpackage

[design/spaf_lane.sv]
// ----------------------------------------------------------------------------
// spaf_lane: binary to decimal conversion lane
// Four register stages, each extracting one decimal digit by parallel
// compares against multiples of its weight and one subtract. The units
// digit is the remainder left after the last stage.
// ----------------------------------------------------------------------------
module spaf_lane #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [SAMPLE_BITS-1:0] value,
  output spaf_pkg::lane_res_t    res
);
  import spaf_pkg::*;

  localparam int STAGES = NUM_DIGITS - 1;

  logic [SAMPLE_BITS-1:0]     rem_r [0:STAGES-1];
  logic [NUM_DIGITS-1:0][3:0] dig_r [0:STAGES-1];

  // One digit per stage, most significant first.
  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int W = 10 ** (STAGES - k);

    logic [SAMPLE_BITS-1:0]     rem_in;
    logic [NUM_DIGITS-1:0][3:0] dig_in;
    logic [NUM_DIGITS-1:0][3:0] dig_out;
    logic [16:0]                ext;
    logic [16:0]                sel;
    logic [3:0]                 d;

    if (k == 0) begin : g_first
      assign rem_in = value;
      assign dig_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dig_in = dig_r[k-1];
    end

    // The largest multiple of the weight that fits gives the digit.
    always_comb begin
      ext = 17'(rem_in);
      d   = 4'd0;
      sel = 17'd0;
      for (int j = 1; j < 10; j++) begin
        if (ext >= 17'(j * W)) begin
          d   = 4'(j);
          sel = 17'(j * W);
        end
      end
      dig_out             = dig_in;
      dig_out[STAGES - k] = d;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= SAMPLE_BITS'(ext - sel);
        dig_r[k] <= dig_out;
      end
    end
  end

  // Assemble the digits and count the significant ones.
  always_comb begin
    res.digit    = dig_r[STAGES-1];
    res.digit[0] = 4'(rem_r[STAGES-1]);
    res.ndig     = DIGIT_IDX_W'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (res.digit[i] != 4'd0) begin
        res.ndig = DIGIT_IDX_W'(i + 1);
      end
    end
  end

endmodule

[design/spaf_serial.sv]
// ----------------------------------------------------------------------------
// spaf_serial: record merge and byte sequencer
// Takes the digits of both lanes as one record and walks through label,
// significant digits, LF and CR for x and then y, one byte per item.
// ----------------------------------------------------------------------------
module spaf_serial (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rec_valid,
  input  spaf_pkg::lane_res_t x_res,
  input  spaf_pkg::lane_res_t y_res,
  output logic                rec_take,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,   // [7:0] out_char
  output logic                out_tlast    // last_char
);
  import spaf_pkg::*;

  fmt_state_t                 state_r, state_nxt;
  logic [DIGIT_IDX_W-1:0]     ptr_r, ptr_nxt;
  logic [NUM_DIGITS-1:0][3:0] xdig_r, ydig_r;
  logic [DIGIT_IDX_W-1:0]     yn_r;

  // State and digit pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // The record's digits are held while its bytes go out.
  always_ff @(posedge clk) begin
    if (rec_take) begin
      xdig_r <= x_res.digit;
      ydig_r <= y_res.digit;
      yn_r   <= y_res.ndig;
    end
  end

  // Next state, record take and the byte on the output.
  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    out_tvalid = (state_r != ST_IDLE);
    out_tlast  = 1'b0;
    out_tdata  = 8'd0;
    rec_take   = rec_valid &&
                 ((state_r == ST_IDLE) || ((state_r == ST_CR_Y) && out_tready));
    unique case (state_r)
      ST_IDLE: begin
        if (rec_take) begin
          state_nxt = ST_LBL_X;
          ptr_nxt   = x_res.ndig - DIGIT_IDX_W'(1);
        end
      end
      ST_LBL_X: begin
        out_tdata = ASCII_X;
        if (out_tready) state_nxt = ST_DIG_X;
      end
      ST_DIG_X: begin
        out_tdata = ASCII_ZERO + 8'(xdig_r[ptr_r]);
        if (out_tready) begin
          if (ptr_r == '0) state_nxt = ST_LF_X;
          else ptr_nxt = ptr_r - DIGIT_IDX_W'(1);
        end
      end
      ST_LF_X: begin
        out_tdata = ASCII_LF;
        if (out_tready) state_nxt = ST_CR_X;
      end
      ST_CR_X: begin
        out_tdata = ASCII_CR;
        if (out_tready) begin
          state_nxt = ST_LBL_Y;
          ptr_nxt   = yn_r - DIGIT_IDX_W'(1);
        end
      end
      ST_LBL_Y: begin
        out_tdata = ASCII_Y;
        if (out_tready) state_nxt = ST_DIG_Y;
      end
      ST_DIG_Y: begin
        out_tdata = ASCII_ZERO + 8'(ydig_r[ptr_r]);
        if (out_tready) begin
          if (ptr_r == '0) state_nxt = ST_LF_Y;
          else ptr_nxt = ptr_r - DIGIT_IDX_W'(1);
        end
      end
      ST_LF_Y: begin
        out_tdata = ASCII_LF;
        if (out_tready) state_nxt = ST_CR_Y;
      end
      ST_CR_Y: begin
        out_tdata = ASCII_CR;
        out_tlast = 1'b1;
        if (out_tready) begin
          if (rec_take) begin
            state_nxt = ST_LBL_X;
            ptr_nxt   = x_res.ndig - DIGIT_IDX_W'(1);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[design/sample_pair_ascii_formatter_unit.sv]
// ----------------------------------------------------------------------------
// sample_pair_ascii_formatter_unit: x/y sample pair to ASCII record
// Converts each pair of samples into "X<digits>\n\rY<digits>\n\r".
// ----------------------------------------------------------------------------
// Each input item carries an x and a y sample; the block answers with one
// record of 8 to 14 output items (one ASCII byte each), the final CR marked
// by out_tlast. Two conversion lanes turn x and y into decimal digits side
// by side in a four-stage pipeline, and the sequencer takes a record's
// digits from the last stage before its first byte is offered. The output
// side sends one byte per cycle while out_tready is high, which sets the
// rate: one item per record, whose length is 14 items when both samples
// have four digits (up to 16 when SAMPLE_BITS allows five digits). The
// next record is held in the pipeline while the current one drains, so
// records follow each other without gaps.
module sample_pair_ascii_formatter_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [SAMPLE_BITS-1:0] x_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] y_sample,
  // zero fill above
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,   // [7:0] out_char
  output logic                out_tlast    // last_char
);
  import spaf_pkg::*;

  localparam int STAGES = NUM_DIGITS - 1;

  logic [STAGES-1:0] vld_r;
  logic              adv;
  logic              rec_take;
  lane_res_t         x_res;
  lane_res_t         y_res;

  // The lane pipeline moves whenever its last stage is empty or taken.
  assign adv       = !vld_r[STAGES-1] || rec_take;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STAGES-2:0], in_tvalid};
    end
  end

  // One lane per sample.
  spaf_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk   (clk),
    .en    (adv),
    .value (in_tdata[SAMPLE_BITS-1:0]),
    .res   (x_res)
  );

  spaf_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk   (clk),
    .en    (adv),
    .value (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .res   (y_res)
  );

  // Merge both lanes into one record and send it byte by byte.
  spaf_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (vld_r[STAGES-1]),
    .x_res      (x_res),
    .y_res      (y_res),
    .rec_take   (rec_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A converted record waiting for the sequencer is never dropped.
  a_rec_held: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[STAGES-1] && !rec_take |=> vld_r[STAGES-1])
    else $error("waiting record lost from lane pipeline");

  // The record ends on a CR.
  a_last_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == ASCII_CR)
    else $error("last byte of record is not CR");

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

[dv/sample_pair_ascii_formatter_unit_test.sv]
// ----------------------------------------------------------------------------
// sample_pair_ascii_formatter_unit_test: record checker for the x/y formatter
// Sends pairs of samples under bursty input and stalling output, predicts
// each ASCII record byte by byte and compares every output item in order.
// ----------------------------------------------------------------------------
module sample_pair_ascii_formatter_unit_test;
  import spaf_pkg::*;

  localparam int SAMPLE_BITS = 12;
  localparam int TDATA_W     = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int DRAIN_CYCLES = 20;

  // One expected output item: an ASCII byte and its end-of-record flag.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } record_byte_t;

  // Output stall styles, switched at random intervals.
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_SPARSE,
    RX_BURSTY
  } rx_style_t;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic               out_tlast;

  record_byte_t pending_chars[$];
  record_byte_t expected_char;
  int unsigned  mismatch_count = 0;

  // Sender pacing.
  bit          tx_no_idle    = 1'b0;
  int unsigned tx_burst_left = 0;

  // Receiver pacing.
  bit          rx_hold_ready = 1'b0;
  rx_style_t   rx_style      = RX_STEADY;
  int unsigned rx_phase_left = 0;
  int unsigned rx_stall_run  = 0;

  sample_pair_ascii_formatter_unit #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Clock with a period of four time units.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Append the record that one sample pair must produce.
  function automatic void queue_record(input logic [SAMPLE_BITS-1:0] x_val,
                                       input logic [SAMPLE_BITS-1:0] y_val);
    int unsigned weights[5] = '{10000, 1000, 100, 10, 1};
    int unsigned value;
    logic [7:0]  label;
    for (int lane = 0; lane < 2; lane++) begin
      value = (lane == 0) ? x_val : y_val;
      label = (lane == 0) ? ASCII_X : ASCII_Y;
      pending_chars.push_back(record_byte_t'{label, 1'b0});
      // Leading zeros are dropped, but the units digit always appears.
      for (int i = 0; i < 5; i++) begin
        if (value >= weights[i] || weights[i] == 1)
          pending_chars.push_back(
            record_byte_t'{ASCII_ZERO + 8'((value / weights[i]) % 10), 1'b0});
      end
      pending_chars.push_back(record_byte_t'{ASCII_LF, 1'b0});
      pending_chars.push_back(record_byte_t'{ASCII_CR, 1'b1 & (lane == 1)});
    end
  endfunction

  // Pick a sample from one of four digit-count ranges or from the full range at random.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 4))
      0:       return SAMPLE_BITS'($urandom_range(0, 9));
      1:       return SAMPLE_BITS'($urandom_range(10, 99));
      2:       return SAMPLE_BITS'($urandom_range(100, 999));
      3:       return SAMPLE_BITS'($urandom_range(1000, 4095));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Send one sample pair; called and returning at a falling edge.
  task automatic send_pair(input logic [SAMPLE_BITS-1:0] x_val,
                           input logic [SAMPLE_BITS-1:0] y_val);
    logic [TDATA_W-1:0] word;
    int unsigned        gap;
    word = '0;
    word[SAMPLE_BITS-1:0]             = x_val;
    word[2*SAMPLE_BITS-1:SAMPLE_BITS] = y_val;
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    queue_record(x_val, y_val);
    @(negedge clk);
    // Bursts of back-to-back items separated by idle gaps of random length.
    if (!tx_no_idle) begin
      if (tx_burst_left == 0) begin
        gap           = $urandom_range(1, 18);
        tx_burst_left = $urandom_range(1, 12);
        in_tvalid <= 1'b0;
        in_tdata  <= TDATA_W'($urandom);
        repeat (gap) @(negedge clk);
      end else begin
        tx_burst_left--;
      end
    end
  endtask

  // Receiver readiness: steady, sparse random stalls, or long stall runs.
  always @(negedge clk) begin
    if (rx_hold_ready) begin
      out_tready <= 1'b1;
    end else begin
      if (rx_phase_left == 0) begin
        rx_style      = rx_style_t'($urandom_range(0, 2));
        rx_phase_left = $urandom_range(20, 150);
      end else begin
        rx_phase_left--;
      end
      case (rx_style)
        RX_STEADY: begin
          out_tready <= 1'b1;
        end
        RX_SPARSE: begin
          out_tready <= ($urandom_range(0, 2) != 0);
        end
        default: begin
          if (rx_stall_run > 0) begin
            rx_stall_run--;
            out_tready <= 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            rx_stall_run = $urandom_range(1, 8);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Compare each accepted output item with the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual char=%h last=%b",
                 $time, out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        expected_char = pending_chars.pop_front();
        if (out_tdata !== expected_char.code) begin
          $display("%0t: char mismatch, expected %h actual %h",
                   $time, expected_char.code, out_tdata);
          mismatch_count++;
        end
        if (out_tlast !== expected_char.last) begin
          $display("%0t: last mismatch, expected %b actual %b",
                   $time, expected_char.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Full-scale and zero samples on both axes, and one pair of mid-range values.
  task automatic test_extremes();
    send_pair(12'd0, 12'd0);
    send_pair(12'd4095, 12'd4095);
    send_pair(12'd0, 12'd4095);
    send_pair(12'd4095, 12'd0);
    send_pair(12'd2730, 12'd1365);
  endtask

  // Values on each side of a change in the digit count, and some with inner zero digits.
  task automatic test_digit_boundaries();
    send_pair(12'd1, 12'd9);
    send_pair(12'd10, 12'd99);
    send_pair(12'd100, 12'd999);
    send_pair(12'd1000, 12'd4000);
    send_pair(12'd9, 12'd10);
    send_pair(12'd99, 12'd100);
    send_pair(12'd999, 12'd1000);
    send_pair(12'd1005, 12'd101);
    send_pair(12'd3070, 12'd0);
    send_pair(12'd0, 12'd1);
  endtask

  // Records at full rate: no input gaps and an always-ready receiver.
  task automatic test_back_to_back();
    tx_no_idle    = 1'b1;
    rx_hold_ready = 1'b1;
    for (int i = 0; i < 30; i++)
      send_pair(pick_sample(), pick_sample());
    tx_no_idle    = 1'b0;
    rx_hold_ready = 1'b0;
  endtask

  // Random pairs under random pacing on both sides.
  task automatic test_random_pairs();
    for (int i = 0; i < 385; i++)
      send_pair(pick_sample(), pick_sample());
  endtask

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_digit_boundaries();
    test_back_to_back();
    test_random_pairs();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sample_pair_ascii_formatter_unit_test: clean");
    end else begin
      $display("sample_pair_ascii_formatter_unit_test: errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("%0t: timeout with %0d bytes outstanding", $time, pending_chars.size());
    $display("sample_pair_ascii_formatter_unit_test: errors");
    $finish;
  end

endmodule
